// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock with an active-low reset.
`define ASSERT_CLK_RSTN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Implication checked on the stream clock and reset.
`define ASSERT_STREAM(label, prop, msg) \
    `ASSERT_CLK_RSTN(label, aclk, aresetn, prop, msg)

`endif

// ----- src/ahfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ahfr_pkg
// Types, codes and character helpers of the ASCII hex frame receiver.
// ----------------------------------------------------------------------------
package ahfr_pkg;

    localparam int MAX_FRAME_CHARS_DEF = 512;

    localparam logic [6:0] CH_ENQ = 7'h05;
    localparam logic [6:0] CH_STX = 7'h02;
    localparam logic [6:0] CH_ETX = 7'h03;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_SUMHI = 3'd3;
    localparam logic [2:0] PH_SUMLO = 3'd4;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_ENQ  = 3'd1;
    localparam logic [2:0] EV_CMD  = 3'd2;
    localparam logic [2:0] EV_DATA = 3'd3;
    localparam logic [2:0] EV_GOOD = 3'd4;
    localparam logic [2:0] EV_BAD  = 3'd5;
    localparam logic [2:0] EV_OVER = 3'd6;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] running_sum;
        logic [3:0] high_nibble;
        logic       digit_pending;
        logic [7:0] byte_index;
        logic       sum_mismatch;
    } ahfr_state_t;

    typedef struct packed {
        logic [7:0] data_position;
        logic [7:0] value;
        logic [2:0] event_kind;
    } ahfr_result_t;

    function automatic logic [3:0] digit_value(input logic [6:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 7'h30 && c <= 7'h39) begin
            d = c[3:0];
        end else if (c >= 7'h41 && c <= 7'h46) begin
            d = 4'(c - 7'h37);
        end
        return d;
    endfunction

    function automatic logic [6:0] hex_upper(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10) begin
            c = 7'h30 + {3'd0, n};
        end else begin
            c = 7'h37 + {3'd0, n};
        end
        return c;
    endfunction

endpackage

// ----- src/ahfr_parser.sv -----
// ----------------------------------------------------------------------------
// ahfr_parser
// Next-state and result logic for one received character.
// ----------------------------------------------------------------------------
module ahfr_parser #(
    parameter int MAX_FRAME_CHARS = ahfr_pkg::MAX_FRAME_CHARS_DEF,
    parameter int CNT_W           = $clog2(MAX_FRAME_CHARS + 1)
) (
    input  logic [7:0]           rx_char,
    input  ahfr_pkg::ahfr_state_t state,
    input  logic [CNT_W-1:0]     char_count,
    output ahfr_pkg::ahfr_state_t state_next,
    output logic [CNT_W-1:0]     char_count_next,
    output ahfr_pkg::ahfr_result_t result
);

    logic [6:0] c;
    logic [3:0] dig;
    logic       in_frame;

    assign c        = rx_char[6:0];
    assign dig      = ahfr_pkg::digit_value(c);
    assign in_frame = (state.phase >= ahfr_pkg::PH_CMD) && (state.phase <= ahfr_pkg::PH_SUMLO);

    always_comb begin
        state_next      = state;
        char_count_next = char_count;
        result          = '0;
        result.event_kind = ahfr_pkg::EV_NONE;
        priority if (c == ahfr_pkg::CH_ENQ) begin
            state_next.phase  = ahfr_pkg::PH_IDLE;
            result.event_kind = ahfr_pkg::EV_ENQ;
        end else if (c == ahfr_pkg::CH_STX) begin
            state_next.phase         = ahfr_pkg::PH_CMD;
            state_next.running_sum   = 8'd0;
            state_next.high_nibble   = 4'd0;
            state_next.digit_pending = 1'b0;
            state_next.byte_index    = 8'd0;
            state_next.sum_mismatch  = 1'b0;
            char_count_next          = CNT_W'(1);
        end else if (!in_frame) begin
            state_next.phase = ahfr_pkg::PH_IDLE;
        end else if (char_count >= CNT_W'(MAX_FRAME_CHARS)) begin
            state_next.phase  = ahfr_pkg::PH_IDLE;
            result.event_kind = ahfr_pkg::EV_OVER;
        end else begin
            char_count_next = char_count + CNT_W'(1);
            priority if (state.phase == ahfr_pkg::PH_CMD || state.phase == ahfr_pkg::PH_DATA) begin
                state_next.running_sum = state.running_sum + {1'b0, c};
                priority if (c == ahfr_pkg::CH_ETX) begin
                    state_next.digit_pending = 1'b0;
                    state_next.phase         = ahfr_pkg::PH_SUMHI;
                end else if (state.phase == ahfr_pkg::PH_CMD) begin
                    result.event_kind = ahfr_pkg::EV_CMD;
                    result.value      = {1'b0, c};
                    state_next.phase  = ahfr_pkg::PH_DATA;
                end else if (!state.digit_pending) begin
                    state_next.high_nibble   = dig;
                    state_next.digit_pending = 1'b1;
                end else begin
                    result.event_kind        = ahfr_pkg::EV_DATA;
                    result.value             = {state.high_nibble, dig};
                    result.data_position     = state.byte_index;
                    state_next.byte_index    = state.byte_index + 8'd1;
                    state_next.digit_pending = 1'b0;
                end
            end else if (state.phase == ahfr_pkg::PH_SUMHI) begin
                state_next.sum_mismatch = (c != ahfr_pkg::hex_upper(state.running_sum[7:4]));
                state_next.phase        = ahfr_pkg::PH_SUMLO;
            end else begin
                if (state.sum_mismatch || (c != ahfr_pkg::hex_upper(state.running_sum[3:0]))) begin
                    result.event_kind = ahfr_pkg::EV_BAD;
                end else begin
                    result.event_kind = ahfr_pkg::EV_GOOD;
                end
                state_next.phase = ahfr_pkg::PH_IDLE;
            end
        end
    end

endmodule

// ----- src/ascii_hex_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_core
// Decodes STX/ETX framed ASCII hex characters into command, data,
// checksum, enquiry and overflow events.
// ----------------------------------------------------------------------------
// Every received character yields exactly one event item, in the cycle after it
// is taken. A new character is accepted in every cycle in which the event
// register is empty or is being read, so the block sustains one character per
// clock; the only loops, the state and count registers, update in one pass.
module ascii_hex_frame_receiver_core #(
    parameter int MAX_FRAME_CHARS = ahfr_pkg::MAX_FRAME_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [2:0] event_kind, [10:3] value,
                                        // [18:11] data_position, [23:19] zero
);

    localparam int CNT_W = $clog2(MAX_FRAME_CHARS + 1);

    ahfr_pkg::ahfr_state_t  state_reg, state_next;
    ahfr_pkg::ahfr_result_t result_reg, result_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   m_valid_reg;
    logic                   accept;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ahfr_parser #(
        .MAX_FRAME_CHARS(MAX_FRAME_CHARS),
        .CNT_W          (CNT_W)
    ) u_parser (
        .rx_char        (s_axis_tdata),
        .state          (state_reg),
        .char_count     (count_reg),
        .state_next     (state_next),
        .char_count_next(count_next),
        .result         (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, result_reg};

endmodule

// ----- src/ahfr_checker.sv -----
// ----------------------------------------------------------------------------
// ahfr_checker
// Port-level checks of the ASCII hex frame receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ahfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic       in_take;
    logic       stall;
    logic       enq_in;
    logic       stx_in;
    logic [2:0] out_kind;
    logic       plain_out;

    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign stall     = m_axis_tvalid && !m_axis_tready;
    assign enq_in    = in_take && (s_axis_tdata[6:0] == ahfr_pkg::CH_ENQ);
    assign stx_in    = in_take && (s_axis_tdata[6:0] == ahfr_pkg::CH_STX);
    assign out_kind  = m_axis_tdata[2:0];
    assign plain_out = m_axis_tvalid && (out_kind != ahfr_pkg::EV_CMD)
                       && (out_kind != ahfr_pkg::EV_DATA);

    `ASSERT_STREAM(a_out_hold, stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
    `ASSERT_STREAM(a_enq_ack, enq_in |=> m_axis_tvalid && out_kind == ahfr_pkg::EV_ENQ, "no enquiry ack")
    `ASSERT_STREAM(a_value_zero, plain_out |-> m_axis_tdata[23:3] == 21'd0, "value set on a plain item")
    `ASSERT_STREAM(a_stx_silent, stx_in |=> m_axis_tvalid && out_kind == ahfr_pkg::EV_NONE, "start gave an event")

endmodule

bind ascii_hex_frame_receiver_core ahfr_checker u_ahfr_checker (.*);
